/* sv/pes_hsp_pkg.sv */
// ----------------------------------------------------------------------------
// pes_hsp_pkg
// shared types, codes and helpers of the PES header stream parser
// ----------------------------------------------------------------------------
package pes_hsp_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MARKER   = 3'd1,
    ST_HDR_LEN  = 3'd2,
    ST_PTS_PFX  = 3'd3,
    ST_DTS_PFX  = 3'd4,
    ST_ZERO_LEN = 3'd5
  } status_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_AUDIO_ID  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VIDEO_NIB = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SKIP      = 2'd2;

  localparam logic [7:0] AUDIO_ID_RST  = 8'hC0;
  localparam logic [3:0] VIDEO_NIB_RST = 4'hE;
  localparam logic       SKIP_RST      = 1'b1;

  localparam logic [23:0] WIN_IDLE  = 24'hFFFFFF;
  localparam logic [23:0] WIN_START = 24'h000001;

  localparam logic [5:0] IDX_FIRST   = 6'd4;
  localparam logic [5:0] IDX_LEN_LO  = 6'd5;
  localparam logic [5:0] IDX_MARKER  = 6'd6;
  localparam logic [5:0] IDX_FLAGS   = 6'd7;
  localparam logic [5:0] IDX_HDR_LEN = 6'd8;
  localparam logic [5:0] IDX_PTS     = 6'd9;
  localparam logic [5:0] IDX_PTS_END = 6'd13;
  localparam logic [5:0] IDX_DTS     = 6'd14;
  localparam logic [5:0] IDX_DTS_END = 6'd18;
  localparam logic [5:0] IDX_EXT     = 6'd20;
  localparam logic [5:0] IDX_EXT_END = 6'd23;
  localparam logic [5:0] IDX_TYPE    = 6'd29;
  localparam logic [5:0] IDX_LAST    = 6'd35;

  localparam logic [7:0] MARKER_MASK = 8'hC0;
  localparam logic [7:0] MARKER_VAL  = 8'h80;
  localparam logic [7:0] HDR_LEN_VAL = 8'd27;
  localparam logic [3:0] PFX_PTS_DTS = 4'h3;
  localparam logic [3:0] PFX_PTS     = 4'h2;
  localparam logic [3:0] PFX_DTS     = 4'h1;
  localparam logic [7:0] VIDEO_MIN   = 8'hE0;

  // one byte of a 33-bit time stamp, pos counts from the prefix byte
  function automatic logic [32:0] ts_step(logic [32:0] acc, logic [2:0] pos,
                                          logic [7:0] b);
    logic [32:0] r;
    unique case (pos)
      3'd0:          r = {30'd0, b[3:1]};
      3'd1, 3'd3:    r = {acc[24:0], b};
      default:       r = {acc[25:0], b[7:1]};
    endcase
    return r;
  endfunction

endpackage

/* sv/pes_header_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// pes_header_stream_parser_core
// PES header parser: start code hunt, fixed 36-byte header walk, one result
// per header, optional payload skip
// ----------------------------------------------------------------------------
// Usage: bytes enter on the input channel (in_valid_i / in_stall_o,
// data_byte_i), one byte per cycle. After 00 00 01 and an accepted stream id
// the block walks 32 more header bytes; the request that carries header
// byte 35 produces one result request on the output channel (out_valid_o /
// out_stall_i) with status, ids, flags, time stamps, length and frame type.
// The result appears the cycle after header byte 35 is accepted. Throughput:
// one byte per cycle; every byte only updates the phase, sync window, byte and
// skip counters and field registers, all set in a single register stage. A
// held result sits in the output register while further bytes are still
// accepted; only header byte 35 waits (in_stall_o high) while that register
// is full and stalled. Configuration registers (audio id, video id nibble,
// skip flag) are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must do so only while the parser is idle, which the block does not enforce.
// Reset clears the parser to hunting with an all-ones sync window and loads
// the default register values; no result is pending after reset.
// ----------------------------------------------------------------------------
module pes_header_stream_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pes_hsp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [7:0]                     pes_id_o,
  output logic                           is_video_o,
  output logic                           has_pts_o,
  output logic                           has_dts_o,
  output logic [32:0]                    pts_o,
  output logic [32:0]                    dts_o,
  output logic [31:0]                    es_length_o,
  output logic [3:0]                     pic_type_o
);
  import pes_hsp_pkg::*;

  logic [7:0]  audio_id_q;
  logic [3:0]  video_nib_q;
  logic        skip_en_q;

  phase_e      phase_q, phase_d;
  logic [23:0] win_q, win_d;
  logic [5:0]  idx_q, idx_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  flags_q, flags_d;
  logic [2:0]  err_q, err_d;
  logic [32:0] pts_q, pts_d;
  logic [32:0] dts_q, dts_d;
  logic [15:0] slen_q, slen_d;
  logic [31:0] llen_q, llen_d;
  logic [3:0]  type_q, type_d;
  logic [31:0] skip_q, skip_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [7:0]  pes_id_q;
  logic        is_video_q, has_pts_q, has_dts_q;
  logic [32:0] pts_out_q, dts_out_q;
  logic [31:0] len_out_q;
  logic [3:0]  type_out_q;

  logic        in_acc;
  logic        head_last;
  logic        hunt_hit;
  logic        pf, df;
  logic [31:0] len;
  logic [2:0]  fin_err;
  logic        hdr_ok;
  logic        skip_done;
  logic [7:0]  b;

  assign b         = data_byte_i;
  assign head_last = (phase_q == PH_HEAD) && (idx_q == IDX_LAST);
  assign in_stall_o = out_valid_q && out_stall_i && head_last;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign hunt_hit  = (win_q == WIN_START) && ((b == audio_id_q) || (b[7:4] == video_nib_q));
  assign pf        = flags_q[7];
  assign df        = flags_q[6];
  assign len       = flags_q[0] ? llen_q : {16'd0, slen_q};
  assign fin_err   = (err_q != ST_OK) ? err_q
                   : ((len == 32'd0) ? ST_ZERO_LEN : ST_OK);
  assign hdr_ok    = (fin_err == ST_OK);
  assign skip_done = (skip_q == 32'd1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_id_q  <= AUDIO_ID_RST;
      video_nib_q <= VIDEO_NIB_RST;
      skip_en_q   <= SKIP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AUDIO_ID:  audio_id_q  <= cfg_wdata_i;
        REG_VIDEO_NIB: video_nib_q <= cfg_wdata_i[3:0];
        REG_SKIP:      skip_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_HEAD: begin
          if (idx_q == IDX_LAST) begin
            phase_d = (hdr_ok && skip_en_q) ? PH_SKIP : PH_HUNT;
          end
        end
        PH_SKIP: begin
          if (skip_done) phase_d = PH_HUNT;
        end
        default: begin
          phase_d = hunt_hit ? PH_HEAD : PH_HUNT;
        end
      endcase
    end
  end

  // header fields
  always_comb begin
    win_d   = win_q;
    idx_d   = idx_q;
    id_d    = id_q;
    flags_d = flags_q;
    err_d   = err_q;
    pts_d   = pts_q;
    dts_d   = dts_q;
    slen_d  = slen_q;
    llen_d  = llen_q;
    type_d  = type_q;
    skip_d  = skip_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_done) win_d = WIN_IDLE;
        end
        PH_HEAD: begin
          if (idx_q == IDX_FIRST) slen_d = {b, 8'd0};
          else if (idx_q == IDX_LEN_LO) slen_d = {slen_q[15:8], b};
          else if (idx_q == IDX_MARKER) begin
            if ((b & MARKER_MASK) != MARKER_VAL && err_q == ST_OK) err_d = ST_MARKER;
          end else if (idx_q == IDX_FLAGS) flags_d = b;
          else if (idx_q == IDX_HDR_LEN) begin
            if (b != HDR_LEN_VAL && err_q == ST_OK) err_d = ST_HDR_LEN;
          end else if (idx_q >= IDX_PTS && idx_q <= IDX_PTS_END) begin
            if (idx_q == IDX_PTS && pf && err_q == ST_OK
                && b[7:4] != (df ? PFX_PTS_DTS : PFX_PTS)) err_d = ST_PTS_PFX;
            pts_d = ts_step(pts_q, 3'(idx_q - IDX_PTS), b);
          end else if (idx_q >= IDX_DTS && idx_q <= IDX_DTS_END) begin
            if (idx_q == IDX_DTS && pf && df && err_q == ST_OK
                && b[7:4] != PFX_DTS) err_d = ST_DTS_PFX;
            dts_d = ts_step(dts_q, 3'(idx_q - IDX_DTS), b);
          end else if (idx_q >= IDX_EXT && idx_q <= IDX_EXT_END) begin
            llen_d = {llen_q[23:0], b};
          end else if (idx_q == IDX_TYPE) type_d = b[3:0];

          if (idx_q == IDX_LAST) begin
            idx_d  = 6'd0;
            win_d  = WIN_IDLE;
            err_d  = fin_err;
            skip_d = (hdr_ok && skip_en_q) ? len : skip_q;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
        default: begin
          if (hunt_hit) begin
            idx_d   = IDX_FIRST;
            id_d    = b;
            flags_d = 8'd0;
            err_d   = ST_OK;
            pts_d   = 33'd0;
            dts_d   = 33'd0;
            slen_d  = 16'd0;
            llen_d  = 32'd0;
            type_d  = 4'd0;
            win_d   = WIN_IDLE;
          end else begin
            win_d = {win_q[15:0], b};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win_q   <= WIN_IDLE;
      idx_q   <= 6'd0;
      id_q    <= 8'd0;
      flags_q <= 8'd0;
      err_q   <= ST_OK;
      pts_q   <= 33'd0;
      dts_q   <= 33'd0;
      slen_q  <= 16'd0;
      llen_q  <= 32'd0;
      type_q  <= 4'd0;
      skip_q  <= 32'd0;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      idx_q   <= idx_d;
      id_q    <= id_d;
      flags_q <= flags_d;
      err_q   <= err_d;
      pts_q   <= pts_d;
      dts_q   <= dts_d;
      slen_q  <= slen_d;
      llen_q  <= llen_d;
      type_q  <= type_d;
      skip_q  <= skip_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && head_last) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && head_last) begin
      status_q    <= fin_err;
      pes_id_q    <= id_q;
      is_video_q  <= (id_q >= VIDEO_MIN);
      has_pts_q   <= pf;
      has_dts_q   <= df;
      pts_out_q   <= (hdr_ok && pf) ? pts_q : 33'd0;
      dts_out_q   <= (hdr_ok && pf && df) ? dts_q : 33'd0;
      len_out_q   <= hdr_ok ? len : 32'd0;
      type_out_q  <= hdr_ok ? type_q : 4'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign pes_id_o     = pes_id_q;
  assign is_video_o   = is_video_q;
  assign has_pts_o    = has_pts_q;
  assign has_dts_o    = has_dts_q;
  assign pts_o        = pts_out_q;
  assign dts_o        = dts_out_q;
  assign es_length_o  = len_out_q;
  assign pic_type_o   = type_out_q;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// byte-stream test of the PES header parser: directed headers, then random
// well-formed, faulty and broken sequences under several register settings,
// each result checked field by field against a built-in header predictor
// ----------------------------------------------------------------------------
module tb_top;
  import pes_hsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pes_id;
    logic        is_video;
    logic        has_pts;
    logic        has_dts;
    logic [32:0] pts;
    logic [32:0] dts;
    logic [31:0] es_length;
    logic [3:0]  pic_type;
  } pes_result_t;

  typedef enum int {
    FLT_NONE, FLT_MARKER, FLT_HDR_LEN, FLT_PTS, FLT_DTS, FLT_MARKER_LEN
  } fault_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = REG_AUDIO_ID;
  logic [7:0]          cfg_wdata_i = 8'h00;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_o;
  logic [7:0]          pes_id_o;
  logic                is_video_o;
  logic                has_pts_o;
  logic                has_dts_o;
  logic [32:0]         pts_o;
  logic [32:0]         dts_o;
  logic [31:0]         es_length_o;
  logic [3:0]          pic_type_o;

  pes_header_stream_parser_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .pes_id_o     (pes_id_o),
    .is_video_o   (is_video_o),
    .has_pts_o    (has_pts_o),
    .has_dts_o    (has_dts_o),
    .pts_o        (pts_o),
    .dts_o        (dts_o),
    .es_length_o  (es_length_o),
    .pic_type_o   (pic_type_o)
  );

  always #6 clk_i = ~clk_i;

  // register copies
  logic [7:0]  cfg_audio = AUDIO_ID_RST;
  logic [3:0]  cfg_vnib  = VIDEO_NIB_RST;
  logic        cfg_skip  = SKIP_RST;

  // parser state
  phase_e      prs_phase = PH_HUNT;
  logic [23:0] prs_window = WIN_IDLE;
  logic [5:0]  hdr_pos = '0;
  logic [7:0]  hdr_bytes [0:35];
  logic [31:0] skip_left = '0;

  pes_result_t expected_headers[$];
  logic [7:0]  stream_bytes[$];
  int          bytes_queued = 0;
  int          headers_queued = 0;
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          byte_taken = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  task automatic parse_byte(input logic [7:0] b);
    pes_result_t r;
    logic [31:0] len;
    logic        pf, df, ok;
    status_e     st;
    case (prs_phase)
      PH_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) begin
          prs_phase  = PH_HUNT;
          prs_window = WIN_IDLE;
        end
      end
      PH_HEAD: begin
        hdr_bytes[hdr_pos] = b;
        if (hdr_pos != IDX_LAST) begin
          hdr_pos = hdr_pos + 6'd1;
        end else begin
          pf  = hdr_bytes[7][7];
          df  = hdr_bytes[7][6];
          len = hdr_bytes[7][0] ? {hdr_bytes[20], hdr_bytes[21], hdr_bytes[22], hdr_bytes[23]}
                                : {16'd0, hdr_bytes[4], hdr_bytes[5]};
          // first failing check in byte order wins, the zero length check comes last
          if ((hdr_bytes[6] & MARKER_MASK) != MARKER_VAL) st = ST_MARKER;
          else if (hdr_bytes[8] != HDR_LEN_VAL) st = ST_HDR_LEN;
          else if (pf && hdr_bytes[9][7:4] != (df ? PFX_PTS_DTS : PFX_PTS)) st = ST_PTS_PFX;
          else if (pf && df && hdr_bytes[14][7:4] != PFX_DTS) st = ST_DTS_PFX;
          else if (len == 0) st = ST_ZERO_LEN;
          else st = ST_OK;
          ok = (st == ST_OK);
          r.status     = st;
          r.pes_id     = hdr_bytes[3];
          r.is_video   = (hdr_bytes[3] >= VIDEO_MIN);
          r.has_pts    = pf;
          r.has_dts    = df;
          r.pts        = (ok && pf) ? {hdr_bytes[9][3:1], hdr_bytes[10], hdr_bytes[11][7:1],
                                       hdr_bytes[12], hdr_bytes[13][7:1]} : '0;
          r.dts        = (ok && pf && df) ? {hdr_bytes[14][3:1], hdr_bytes[15],
                                             hdr_bytes[16][7:1], hdr_bytes[17],
                                             hdr_bytes[18][7:1]} : '0;
          r.es_length  = ok ? len : '0;
          r.pic_type   = ok ? hdr_bytes[29][3:0] : '0;
          expected_headers.push_back(r);
          hdr_pos    = '0;
          prs_window = WIN_IDLE;
          if (ok && cfg_skip) begin
            prs_phase = PH_SKIP;
            skip_left = len;
          end else begin
            prs_phase = PH_HUNT;
          end
        end
      end
      default: begin
        if (prs_window == WIN_START && (b == cfg_audio || b[7:4] == cfg_vnib)) begin
          prs_phase    = PH_HEAD;
          hdr_pos      = IDX_FIRST;
          hdr_bytes[3] = b;
          prs_window   = WIN_IDLE;
        end else begin
          prs_phase  = PH_HUNT;
          prs_window = {prs_window[15:0], b};
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [32:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 13) - 1;
          in_valid_i <= 1'b0;
        end else if (stream_bytes.size() > 0) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= stream_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    pes_result_t due;
    byte_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) parse_byte(data_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_headers.size() == 0) begin
          $error("header result with none expected, pes_id %0h", pes_id_o);
          errors++;
        end else begin
          due = expected_headers.pop_front();
          check_field("status", due.status, status_o);
          check_field("pes_id", due.pes_id, pes_id_o);
          check_field("is_video", due.is_video, is_video_o);
          check_field("has_pts", due.has_pts, has_pts_o);
          check_field("has_dts", due.has_dts, has_dts_o);
          check_field("pts", due.pts, pts_o);
          check_field("dts", due.dts, dts_o);
          check_field("es_length", due.es_length, es_length_o);
          check_field("pic_type", due.pic_type, pic_type_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_id();
    return ($urandom_range(0, 1) == 0) ? cfg_audio : {cfg_vnib, 4'($urandom)};
  endfunction

  function automatic logic [32:0] rand_ts();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {1'($urandom), 32'($urandom)};
    endcase
  endfunction

  // start code, id, header bytes 4..35 and optional payload
  task automatic queue_pes(input logic [7:0] id, input logic [7:0] flags,
                           input logic [31:0] len, input fault_e fault,
                           input logic [32:0] pts_v, input logic [32:0] dts_v,
                           input int payload, input bit fake_sc, input bit zero_tail);
    logic [7:0] h [4:35];
    logic [3:0] pts_pfx, dts_pfx;
    logic [1:0] mk;
    int         fake_at;
    foreach (h[i]) h[i] = 8'($urandom);
    if (flags[0]) {h[20], h[21], h[22], h[23]} = len;
    else {h[4], h[5]} = len[15:0];
    mk = 2'b10;
    if (fault == FLT_MARKER || fault == FLT_MARKER_LEN) begin
      mk = 2'($urandom_range(0, 2));
      if (mk == 2'b10) mk = 2'b11;
    end
    h[6][7:6] = mk;
    h[7] = flags;
    h[8] = HDR_LEN_VAL;
    if (fault == FLT_HDR_LEN || fault == FLT_MARKER_LEN)
      h[8] = HDR_LEN_VAL ^ 8'($urandom_range(1, 255));
    pts_pfx = flags[6] ? PFX_PTS_DTS : PFX_PTS;
    if (!flags[7]) pts_pfx = 4'($urandom);
    else if (fault == FLT_PTS) pts_pfx = pts_pfx ^ 4'($urandom_range(1, 15));
    dts_pfx = PFX_DTS;
    if (!(flags[7] && flags[6])) dts_pfx = 4'($urandom);
    else if (fault == FLT_DTS) dts_pfx = dts_pfx ^ 4'($urandom_range(1, 15));
    h[9]  = {pts_pfx, pts_v[32:30], h[9][0]};
    h[10] = pts_v[29:22];
    h[11] = {pts_v[21:15], h[11][0]};
    h[12] = pts_v[14:7];
    h[13] = {pts_v[6:0], h[13][0]};
    h[14] = {dts_pfx, dts_v[32:30], h[14][0]};
    h[15] = dts_v[29:22];
    h[16] = {dts_v[21:15], h[16][0]};
    h[17] = dts_v[14:7];
    h[18] = {dts_v[6:0], h[18][0]};
    if (zero_tail) begin
      h[34] = 8'h00;
      h[35] = 8'h00;
    end
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(id);
    for (int i = 4; i <= 35; i++) push_byte(h[i]);
    // a start code hidden in the payload must be skipped
    fake_at = (fake_sc && payload >= 4) ? $urandom_range(0, payload - 4) : -1;
    for (int k = 0; k < payload; k++) begin
      if (k == fake_at || k == fake_at + 1) push_byte(8'h00);
      else if (k == fake_at + 2) push_byte(8'h01);
      else if (k == fake_at + 3) push_byte(cfg_audio);
      else push_byte(8'($urandom));
    end
    headers_queued++;
  endtask

  task automatic queue_random_seq();
    int          kind;
    logic [7:0]  flags, b;
    logic [31:0] len;
    fault_e      fault;
    kind  = $urandom_range(0, 99);
    flags = 8'($urandom);
    if (kind < 65) begin
      if (cfg_skip) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
        queue_pes(pick_id(), flags, len, FLT_NONE, rand_ts(), rand_ts(), len,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      end else begin
        if (flags[0]) len = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
        else len = $urandom_range(0, 16'hFFFF);
        queue_pes(pick_id(), flags, len, FLT_NONE, rand_ts(), rand_ts(),
                  $urandom_range(0, 6), 1'b0, $urandom_range(0, 7) == 0);
      end
    end else if (kind < 82) begin
      fault = fault_e'($urandom_range(1, 5));
      len   = $urandom;
      if (fault == FLT_PTS) flags[7] = 1'b1;
      if (fault == FLT_DTS) flags[7:6] = 2'b11;
      if ($urandom_range(0, 5) == 0) begin
        fault = FLT_NONE;
        len   = '0;
      end
      queue_pes(pick_id(), flags, len, fault, rand_ts(), rand_ts(),
                $urandom_range(0, 3), 1'b0, 1'b0);
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
    end else begin
      push_byte(8'h00);
      push_byte(8'h00);
      if ($urandom_range(0, 1) == 0) begin
        // start code with a stream id that is not accepted
        push_byte(8'h01);
        do b = 8'($urandom); while (b == cfg_audio || b[7:4] == cfg_vnib);
        push_byte(b);
      end
    end
  endtask

  task automatic run_random(input int n_bytes, input int n_headers);
    int b0, h0;
    b0 = bytes_queued;
    h0 = headers_queued;
    while (bytes_queued - b0 < n_bytes || headers_queued - h0 < n_headers)
      queue_random_seq();
  endtask

  task automatic wait_all_headers();
    do @(posedge clk_i);
    while (stream_bytes.size() != 0 || in_valid_i || expected_headers.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_AUDIO_ID:  cfg_audio = val;
      REG_VIDEO_NIB: cfg_vnib = val[3:0];
      REG_SKIP:      cfg_skip = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] audio, input logic [3:0] nib, input logic skip);
    write_reg(REG_AUDIO_ID, audio);
    write_reg(REG_VIDEO_NIB, {4'($urandom), nib});
    write_reg(REG_SKIP, {7'($urandom), skip});
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: audio C0, video nibble E, payload skip on
    queue_pes(8'hC0, 8'hC0, 3, FLT_NONE, '1, '0, 3, 1'b0, 1'b0);
    queue_pes(8'hE5, 8'h81, 5, FLT_NONE, '0, rand_ts(), 5, 1'b1, 1'b0);
    queue_pes(8'hEF, 8'h40, 1, FLT_NONE, rand_ts(), rand_ts(), 1, 1'b0, 1'b0);
    queue_pes(8'hC0, 8'h00, 2, FLT_MARKER_LEN, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    queue_pes(8'hE0, 8'hC0, 7, FLT_HDR_LEN, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    queue_pes(8'hE1, 8'hC0, 7, FLT_PTS, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    queue_pes(8'hE2, 8'h80, 7, FLT_PTS, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    queue_pes(8'hE3, 8'hC0, 7, FLT_DTS, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    queue_pes(8'hC0, 8'h00, 0, FLT_NONE, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    queue_pes(8'hC0, 8'h01, 0, FLT_NONE, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    // skipped payload ends in 00 00, the following 01 C0 is no start code
    queue_pes(8'hC0, 8'h80, 2, FLT_NONE, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'hC0);
    push_byte(8'h00);
    queue_pes(8'hE7, 8'hC0, 4, FLT_NONE, rand_ts(), rand_ts(), 4, 1'b0, 1'b0);
    wait_all_headers();

    set_config(8'h00, 4'hF, 1'b0);
    queue_pes(8'hFF, 8'hC1, '1, FLT_NONE, '1, '1, 0, 1'b0, 1'b0);
    queue_pes(8'h00, 8'h00, 32'h0000FFFF, FLT_NONE, '0, '0, 0, 1'b0, 1'b0);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'hBD);
    // header ends in 00 00, so 01 00 right after it must not match
    queue_pes(8'hF3, 8'h80, 9, FLT_MARKER, rand_ts(), rand_ts(), 0, 1'b0, 1'b1);
    push_byte(8'h01);
    push_byte(8'h00);
    queue_pes(8'h00, 8'hC0, 300, FLT_NONE, rand_ts(), rand_ts(), 0, 1'b0, 1'b0);
    wait_all_headers();

    set_config(8'($urandom), 4'($urandom), 1'b1);
    run_random(300, 6);
    wait_all_headers();

    idle_on = 1'b0;
    set_config(8'hFF, 4'h0, 1'b1);
    run_random(200, 4);
    wait_all_headers();

    idle_on = 1'b1;
    write_reg(REG_UNUSED, 8'($urandom));
    set_config(8'($urandom), 4'($urandom), 1'b0);
    run_random(300, 6);
    wait_all_headers();

    set_config(8'hC0, 4'hE, 1'b1);
    run_random(300, 6);
    wait_all_headers();

    idle_on = 1'b0;
    set_config(8'($urandom), 4'($urandom), 1'($urandom));
    run_random(250, 5);
    wait_all_headers();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
